// ===== design/nsb_pkg.sv =====
// ----------------------------------------------------------------------------
// nsb_pkg: shared types and constants for the node selection balancer
// Field types of the request, response and register ports, command and mode
// codes, and the constants of the select engine.
// ----------------------------------------------------------------------------
package nsb_pkg;

   localparam int CMD_W      = 3;
   localparam int NODE_W     = 4;
   localparam int MASK_W     = 16;
   localparam int STAT_W     = 16;
   localparam int RESP_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int MAX_SLOTS  = 16;

   typedef logic [CMD_W-1:0]      cmd_type;
   typedef logic [NODE_W-1:0]     node_type;
   typedef logic [MASK_W-1:0]     mask_type;
   typedef logic [STAT_W-1:0]     stat_type;
   typedef logic [RESP_W-1:0]     resp_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // Command codes
   localparam cmd_type CMD_ADD    = 3'd0;
   localparam cmd_type CMD_REMOVE = 3'd1;
   localparam cmd_type CMD_UPDATE = 3'd2;
   localparam cmd_type CMD_HEALTH = 3'd3;
   localparam cmd_type CMD_SELECT = 3'd4;
   localparam cmd_type CMD_QUERY  = 3'd5;
   localparam cmd_type CMD_CLEAR  = 3'd6;

   // Register indexes
   localparam csr_idx_type CSR_ENABLE = 2'd0;
   localparam csr_idx_type CSR_MODE   = 2'd1;

   // Select modes; bit 1 set means a minimum search
   localparam logic [1:0] MODE_RR     = 2'd0;
   localparam logic [1:0] MODE_RANDOM = 2'd1;
   localparam logic [1:0] MODE_LEAST  = 2'd2;
   localparam logic [1:0] MODE_SCORE  = 2'd3;

   // Round robin counter and its remainder unit, four quotient bits a cycle
   localparam int RR_W      = 32;
   localparam int DIV_STEP  = 4;
   localparam int DIV_ITER  = RR_W / DIV_STEP;
   localparam int DIV_CNT_W = $clog2(DIV_ITER);

   // resp / 1000 as (resp * MAGIC) >> 38, exact over 32 bits
   localparam int          RESP_MAGIC_W = 29;
   localparam int          RESP_SHIFT   = 38;
   localparam int          PROD_W       = RESP_W + RESP_MAGIC_W;
   localparam int          QUOT_W       = PROD_W - RESP_SHIFT;
   localparam logic [RESP_MAGIC_W-1:0] RESP_MAGIC = 29'h10624DD3;

   localparam int SUM_W = STAT_W + 1;
   localparam int KEY_W = QUOT_W + 1;

endpackage

// ===== design/node_selection_balancer.sv =====
// ----------------------------------------------------------------------------
// node_selection_balancer: node slot table with a select engine
// Keeps per-slot present, health and load statistics and picks a node by
// round robin, least connections or lowest score.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_*): one command item per handshake. The block takes
//   an item only when its sequencer is idle and then drops req_ready until
//   the item's result has been handed to the response register.
//   Response channel (rsp_*): exactly one item per request. The response
//   register is separate, so a new request is taken while a result waits.
//   Register port (csr_*): always ready; write enable and mode while idle.
//   Steps per item, S = min(NODES, 16):
//     add, remove, update, set health, query, clear: execute, then finish.
//     select, least connections or lowest score: a scan of the S slots; one slot a
//       cycle goes through the score multiplier and the shared compare.
//     select, round robin: a slot scan counts the candidates, the remainder
//       unit reduces rr_count modulo the count, and a second scan walks to the
//       chosen candidate.
//   Reset clears the slot bits, rr_count and both registers at once.
//   When the receiver stalls, the result stays in the response register and
//   the next result waits in the sequencer until it drains.
// ----------------------------------------------------------------------------
module node_selection_balancer #(
   parameter int NODES = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  nsb_pkg::cmd_type      req_cmd,
   input  nsb_pkg::node_type     req_node,
   input  nsb_pkg::mask_type     req_avail_mask,
   input  nsb_pkg::stat_type     req_conn_in,
   input  nsb_pkg::stat_type     req_cpu_in,
   input  nsb_pkg::stat_type     req_mem_in,
   input  nsb_pkg::resp_type     req_resp_in,
   input  logic                  req_health_in,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_ok,
   output nsb_pkg::node_type     rsp_chosen,
   output logic                  rsp_present_out,
   output logic                  rsp_healthy_out,
   output nsb_pkg::stat_type     rsp_conn_out,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  nsb_pkg::csr_idx_type  csr_index,
   input  nsb_pkg::csr_data_type csr_data
);
   import nsb_pkg::*;

   localparam int SLOTS = (NODES < MAX_SLOTS) ? NODES : MAX_SLOTS;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_PICK = 3'd4;
   localparam logic [2:0] S_SEL  = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic                 enable_ff;
   logic [1:0]           mode_ff;

   // Latched request
   cmd_type              cmd_ff, cmd_in;
   node_type             node_ff, node_in;
   logic [SLOTS-1:0]     mask_ff, mask_in;
   stat_type             conn_ff, conn_in;
   stat_type             cpu_ff, cpu_in;
   stat_type             mem_ff, mem_in;
   resp_type             resp_ff, resp_in;
   logic                 health_ff, health_in;

   // Slot table
   logic [SLOTS-1:0]     present_vec_ff, present_vec_in;
   logic [SLOTS-1:0]     health_vec_ff, health_vec_in;
   stat_type             conn_tab_ff [SLOTS];
   stat_type             cpu_tab_ff [SLOTS];
   stat_type             mem_tab_ff [SLOTS];
   resp_type             resp_tab_ff [SLOTS];
   logic                 tab_we;

   // Select engine
   logic [RR_W-1:0]      rr_ff, rr_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic [CNT_W-1:0]     ncand_ff, ncand_in;
   logic [IDX_W-1:0]     first_ff, first_in;
   logic                 p_vld_ff, p_vld_in;
   logic [IDX_W-1:0]     p_idx_ff, p_idx_in;
   logic [SUM_W-1:0]     p_cm_ff, p_cm_in;
   logic [QUOT_W-1:0]    p_q_ff, p_q_in;
   logic                 have_best_ff, have_best_in;
   logic [KEY_W-1:0]     best_ff, best_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [RR_W-1:0]      dvd_ff, dvd_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [CNT_W-1:0]     k_ff, k_in;

   // Pending result and response register
   logic                 res_ok_ff, res_ok_in;
   node_type             res_chosen_ff, res_chosen_in;
   logic                 res_present_ff, res_present_in;
   logic                 res_healthy_ff, res_healthy_in;
   stat_type             res_conn_ff, res_conn_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff;
   node_type             rsp_chosen_ff;
   logic                 rsp_present_ff;
   logic                 rsp_healthy_ff;
   stat_type             rsp_conn_ff;
   logic                 rsp_load;

   logic [IDX_W-1:0]     node_idx;
   logic [IDX_W-1:0]     rd_idx;
   logic                 in_range;
   logic                 rd_cand;
   logic                 rd_pres;
   logic [PROD_W-1:0]    prod;
   logic [KEY_W-1:0]     key;
   logic [CNT_W-1:0]     rem_step;
   logic [CNT_W:0]       rem_t;

   assign node_idx = node_ff[IDX_W-1:0];
   assign in_range = {1'b0, node_ff} < (NODE_W + 1)'(SLOTS);
   assign rd_idx   = (state_ff == S_EXEC) ? node_idx : scan_ff[IDX_W-1:0];
   assign rd_cand  = mask_ff[rd_idx] & health_vec_ff[rd_idx];
   assign rd_pres  = present_vec_ff[rd_idx];
   assign prod     = {{RESP_MAGIC_W{1'b0}}, resp_tab_ff[rd_idx]} *
                     {{RESP_W{1'b0}}, RESP_MAGIC};
   assign key      = {{(KEY_W - SUM_W){1'b0}}, p_cm_ff} + {1'b0, p_q_ff};

   // Remainder unit: four restoring steps on a value below the count
   always_comb begin
      rem_step = rem_ff;
      rem_t    = '0;
      for (int j = 0; j < DIV_STEP; j++) begin
         rem_t = {rem_step, dvd_ff[RR_W-1-j]};
         if (rem_t >= {1'b0, ncand_ff}) begin
            rem_t = rem_t - {1'b0, ncand_ff};
         end
         rem_step = rem_t[CNT_W-1:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      node_in        = node_ff;
      mask_in        = mask_ff;
      conn_in        = conn_ff;
      cpu_in         = cpu_ff;
      mem_in         = mem_ff;
      resp_in        = resp_ff;
      health_in      = health_ff;
      present_vec_in = present_vec_ff;
      health_vec_in  = health_vec_ff;
      tab_we         = 1'b0;
      rr_in          = rr_ff;
      scan_in        = scan_ff;
      ncand_in       = ncand_ff;
      first_in       = first_ff;
      p_vld_in       = 1'b0;
      p_idx_in       = p_idx_ff;
      p_cm_in        = p_cm_ff;
      p_q_in         = p_q_ff;
      have_best_in   = have_best_ff;
      best_in        = best_ff;
      best_idx_in    = best_idx_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      div_cnt_in     = div_cnt_ff;
      k_in           = k_ff;
      res_ok_in      = res_ok_ff;
      res_chosen_in  = res_chosen_ff;
      res_present_in = res_present_ff;
      res_healthy_in = res_healthy_ff;
      res_conn_in    = res_conn_ff;
      rsp_load       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               node_in   = req_node;
               mask_in   = req_avail_mask[SLOTS-1:0];
               conn_in   = req_conn_in;
               cpu_in    = req_cpu_in;
               mem_in    = req_mem_in;
               resp_in   = req_resp_in;
               health_in = req_health_in;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            res_ok_in      = 1'b0;
            res_chosen_in  = '0;
            res_present_in = 1'b0;
            res_healthy_in = 1'b0;
            res_conn_in    = '0;
            state_in       = S_FIN;
            if (enable_ff) begin
               unique case (cmd_ff)
                  CMD_ADD: begin
                     if (in_range && !rd_pres) begin
                        present_vec_in[node_idx] = 1'b1;
                        health_vec_in[node_idx]  = 1'b1;
                        tab_we                   = 1'b1;
                        res_ok_in                = 1'b1;
                     end
                  end
                  CMD_REMOVE: begin
                     // Stats of an absent slot are never read, so drop bits only
                     if (in_range && rd_pres) begin
                        present_vec_in[node_idx] = 1'b0;
                        health_vec_in[node_idx]  = 1'b0;
                        res_ok_in                = 1'b1;
                     end
                  end
                  CMD_UPDATE: begin
                     if (in_range && rd_pres) begin
                        tab_we    = 1'b1;
                        res_ok_in = 1'b1;
                     end
                  end
                  CMD_HEALTH: begin
                     if (in_range) begin
                        health_vec_in[node_idx] = health_ff;
                        res_ok_in               = 1'b1;
                     end
                  end
                  CMD_SELECT: begin
                     scan_in      = '0;
                     ncand_in     = '0;
                     have_best_in = 1'b0;
                     state_in     = S_SCAN;
                  end
                  CMD_QUERY: begin
                     if (in_range) begin
                        res_ok_in      = 1'b1;
                        res_present_in = rd_pres;
                        res_healthy_in = health_vec_ff[node_idx];
                        res_conn_in    = rd_pres ? conn_tab_ff[node_idx] : '0;
                     end
                  end
                  CMD_CLEAR: begin
                     present_vec_in = '0;
                     health_vec_in  = '0;
                     res_ok_in      = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // Compare the slot staged last cycle against the running minimum
            if (p_vld_ff && (!have_best_ff || key < best_ff)) begin
               have_best_in = 1'b1;
               best_in      = key;
               best_idx_in  = p_idx_ff;
            end
            if (scan_ff != CNT_W'(SLOTS)) begin
               if (rd_cand) begin
                  ncand_in = ncand_ff + 1'b1;
                  if (ncand_ff == '0) begin
                     first_in = rd_idx;
                  end
               end
               p_vld_in = rd_cand & rd_pres & mode_ff[1];
               p_idx_in = rd_idx;
               if (mode_ff == MODE_LEAST) begin
                  p_cm_in = {1'b0, conn_tab_ff[rd_idx]};
                  p_q_in  = '0;
               end else begin
                  p_cm_in = {1'b0, cpu_tab_ff[rd_idx]} + {1'b0, mem_tab_ff[rd_idx]};
                  p_q_in  = prod[PROD_W-1:RESP_SHIFT];
               end
               scan_in = scan_ff + 1'b1;
            end else if (!mode_ff[1] && ncand_ff != '0) begin
               dvd_in     = rr_ff;
               rem_in     = '0;
               div_cnt_in = '0;
               state_in   = S_DIV;
            end else begin
               state_in = S_SEL;
            end
         end
         S_DIV: begin
            rem_in     = rem_step;
            dvd_in     = dvd_ff << DIV_STEP;
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_ITER - 1)) begin
               scan_in  = '0;
               k_in     = '0;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            // Walk the candidates until the one at the remainder's position
            scan_in = scan_ff + 1'b1;
            if (rd_cand) begin
               if (k_ff == rem_ff) begin
                  res_ok_in     = 1'b1;
                  res_chosen_in = NODE_W'(rd_idx);
                  rr_in         = rr_ff + 1'b1;
                  state_in      = S_FIN;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         S_SEL: begin
            res_ok_in     = (ncand_ff != '0);
            res_chosen_in = '0;
            if (ncand_ff != '0) begin
               res_chosen_in = NODE_W'(have_best_ff ? best_idx_ff : first_ff);
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         enable_ff      <= 1'b0;
         mode_ff        <= MODE_RR;
         present_vec_ff <= '0;
         health_vec_ff  <= '0;
         rr_ff          <= '0;
         p_vld_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         present_vec_ff <= present_vec_in;
         health_vec_ff  <= health_vec_in;
         rr_ff          <= rr_in;
         p_vld_ff       <= p_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_valid) begin
            if (csr_index == CSR_ENABLE) begin
               enable_ff <= csr_data[0];
            end else if (csr_index == CSR_MODE) begin
               mode_ff <= csr_data[1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      node_ff        <= node_in;
      mask_ff        <= mask_in;
      conn_ff        <= conn_in;
      cpu_ff         <= cpu_in;
      mem_ff         <= mem_in;
      resp_ff        <= resp_in;
      health_ff      <= health_in;
      scan_ff        <= scan_in;
      ncand_ff       <= ncand_in;
      first_ff       <= first_in;
      p_idx_ff       <= p_idx_in;
      p_cm_ff        <= p_cm_in;
      p_q_ff         <= p_q_in;
      have_best_ff   <= have_best_in;
      best_ff        <= best_in;
      best_idx_ff    <= best_idx_in;
      dvd_ff         <= dvd_in;
      rem_ff         <= rem_in;
      div_cnt_ff     <= div_cnt_in;
      k_ff           <= k_in;
      res_ok_ff      <= res_ok_in;
      res_chosen_ff  <= res_chosen_in;
      res_present_ff <= res_present_in;
      res_healthy_ff <= res_healthy_in;
      res_conn_ff    <= res_conn_in;
      if (rsp_load) begin
         rsp_ok_ff      <= res_ok_ff;
         rsp_chosen_ff  <= res_chosen_ff;
         rsp_present_ff <= res_present_ff;
         rsp_healthy_ff <= res_healthy_ff;
         rsp_conn_ff    <= res_conn_ff;
      end
      // Add zeroes the statistics, update writes them
      if (tab_we) begin
         if (cmd_ff == CMD_ADD) begin
            conn_tab_ff[node_idx] <= '0;
            cpu_tab_ff[node_idx]  <= '0;
            mem_tab_ff[node_idx]  <= '0;
            resp_tab_ff[node_idx] <= '0;
         end else begin
            conn_tab_ff[node_idx] <= conn_ff;
            cpu_tab_ff[node_idx]  <= cpu_ff;
            mem_tab_ff[node_idx]  <= mem_ff;
            resp_tab_ff[node_idx] <= resp_ff;
         end
      end
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_chosen      = rsp_chosen_ff;
   assign rsp_present_out = rsp_present_ff;
   assign rsp_healthy_out = rsp_healthy_ff;
   assign rsp_conn_out    = rsp_conn_ff;

   a_div_rem_below_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> rem_ff < ncand_ff)
      else $error("remainder not below candidate count");

   a_pick_in_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PICK |-> (k_ff <= rem_ff) && (scan_ff < CNT_W'(SLOTS)))
      else $error("round robin walk ran past its candidate");

   a_rr_moves_on_pick: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) && (rr_ff != $past(rr_ff)) |-> $past(state_ff == S_PICK))
      else $error("round robin counter changed outside a pick");

   a_sel_not_rr: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEL |-> (ncand_ff == '0) || mode_ff[1])
      else $error("round robin select with candidates reached the minimum path");

endmodule

// ===== sim/nsb_select_checker.sv =====
// ----------------------------------------------------------------------------
// nsb_select_checker: response checker for the node selection balancer
// Watches the register, request and response channels, keeps its own copy of
// the slot table and the select engine, and compares each response item
// field by field with the oldest predicted item.
// ----------------------------------------------------------------------------
module nsb_select_checker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  nsb_pkg::cmd_type      req_cmd,
   input  nsb_pkg::node_type     req_node,
   input  nsb_pkg::mask_type     req_avail_mask,
   input  nsb_pkg::stat_type     req_conn_in,
   input  nsb_pkg::stat_type     req_cpu_in,
   input  nsb_pkg::stat_type     req_mem_in,
   input  nsb_pkg::resp_type     req_resp_in,
   input  logic                  req_health_in,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_ok,
   input  nsb_pkg::node_type     rsp_chosen,
   input  logic                  rsp_present_out,
   input  logic                  rsp_healthy_out,
   input  nsb_pkg::stat_type     rsp_conn_out,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  nsb_pkg::csr_idx_type  csr_index,
   input  nsb_pkg::csr_data_type csr_data,
   output int                    mismatches,
   output int                    outstanding
);
   import nsb_pkg::*;

   localparam int RESP_SCALE = 1000;

   typedef struct packed {
      logic     ok;
      node_type chosen;
      logic     present;
      logic     healthy;
      stat_type conn;
   } outcome_type;

   logic                 enabled;
   logic [1:0]           sel_mode;
   logic [MAX_SLOTS-1:0] slot_present;
   logic [MAX_SLOTS-1:0] slot_healthy;
   stat_type             slot_conn [MAX_SLOTS];
   stat_type             slot_cpu  [MAX_SLOTS];
   stat_type             slot_mem  [MAX_SLOTS];
   resp_type             slot_resp [MAX_SLOTS];
   logic [RR_W-1:0]      rr_count;
   outcome_type          expected_q [$];

   function automatic void wipe_slot(int i);
      slot_present[i] = 1'b0;
      slot_healthy[i] = 1'b0;
      slot_conn[i]    = '0;
      slot_cpu[i]     = '0;
      slot_mem[i]     = '0;
      slot_resp[i]    = '0;
   endfunction

   // Apply one command to the table copy and return the response it must get
   function automatic outcome_type apply_command(cmd_type cmd, node_type node,
                                                 mask_type mask, stat_type conn,
                                                 stat_type cpu, stat_type mem,
                                                 resp_type resp, logic health);
      outcome_type v;
      int          cand [$];
      int          pick;
      logic        have;
      logic [33:0] key;
      logic [33:0] best_key;
      v = '0;
      if (!enabled)
         return v;
      case (cmd)
         CMD_ADD: begin
            if (!slot_present[node]) begin
               wipe_slot(node);
               slot_present[node] = 1'b1;
               slot_healthy[node] = 1'b1;
               v.ok = 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (slot_present[node]) begin
               wipe_slot(node);
               v.ok = 1'b1;
            end
         end
         CMD_UPDATE: begin
            if (slot_present[node]) begin
               slot_conn[node] = conn;
               slot_cpu[node]  = cpu;
               slot_mem[node]  = mem;
               slot_resp[node] = resp;
               v.ok = 1'b1;
            end
         end
         CMD_HEALTH: begin
            slot_healthy[node] = health;
            v.ok = 1'b1;
         end
         CMD_SELECT: begin
            for (int i = 0; i < MAX_SLOTS; i++)
               if (mask[i] && slot_healthy[i])
                  cand.insert(cand.size(), i);
            if (cand.size() != 0) begin
               v.ok = 1'b1;
               if (sel_mode == MODE_LEAST || sel_mode == MODE_SCORE) begin
                  // first strict minimum among present candidates
                  pick = cand[0];
                  have = 1'b0;
                  best_key = '0;
                  foreach (cand[k]) begin
                     if (slot_present[cand[k]]) begin
                        if (sel_mode == MODE_LEAST)
                           key = 34'(slot_conn[cand[k]]);
                        else
                           key = 34'(slot_cpu[cand[k]]) + 34'(slot_mem[cand[k]]) +
                                 34'(slot_resp[cand[k]] / RESP_SCALE);
                        if (!have || key < best_key) begin
                           have = 1'b1;
                           best_key = key;
                           pick = cand[k];
                        end
                     end
                  end
               end else begin
                  pick = cand[rr_count % $unsigned(cand.size())];
                  rr_count = rr_count + 1'b1;
               end
               v.chosen = node_type'(pick);
            end
         end
         CMD_QUERY: begin
            v.ok      = 1'b1;
            v.present = slot_present[node];
            v.healthy = slot_healthy[node];
            v.conn    = slot_conn[node];
         end
         CMD_CLEAR: begin
            for (int i = 0; i < MAX_SLOTS; i++)
               wipe_slot(i);
            v.ok = 1'b1;
         end
         default: ;
      endcase
      return v;
   endfunction

   function automatic void check_field(string name, logic [31:0] want,
                                       logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         enabled  = 1'b0;
         sel_mode = MODE_RR;
         rr_count = '0;
         for (int i = 0; i < MAX_SLOTS; i++)
            wipe_slot(i);
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENABLE: enabled  = csr_data[0];
               CSR_MODE:   sel_mode = csr_data[1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("response item with no request outstanding");
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               check_field("ok", want.ok, rsp_ok);
               check_field("chosen", want.chosen, rsp_chosen);
               check_field("present_out", want.present, rsp_present_out);
               check_field("healthy_out", want.healthy, rsp_healthy_out);
               check_field("conn_out", want.conn, rsp_conn_out);
            end
         end
         if (req_valid && req_ready)
            expected_q.insert(expected_q.size(),
                              apply_command(req_cmd, req_node, req_avail_mask,
                                            req_conn_in, req_cpu_in, req_mem_in,
                                            req_resp_in, req_health_in));
      end
      outstanding = expected_q.size();
   end

endmodule

// ===== sim/node_selection_balancer_tb.sv =====
// ----------------------------------------------------------------------------
// node_selection_balancer_tb: testbench for the node selection balancer
// Drives directed and random command items under every select mode and with
// the block disabled, with bursty requests and a stalling receiver; a checker
// beside the block predicts and compares every response item.
// ----------------------------------------------------------------------------
module node_selection_balancer_tb;
   import nsb_pkg::*;

   localparam int          HOLD_CYCLES  = 300;
   localparam int          TAIL_CYCLES  = 80;
   localparam int          PHASES       = 10;
   localparam int          PHASE_ITEMS  = 80;
   localparam int          IDLE_ITEMS   = 30;
   localparam int          RUN_LIMIT    = 2_000_000;
   localparam cmd_type     CMD_UNUSED   = 3'd7;
   localparam csr_idx_type CSR_SPARE_LO = 2'd2;
   localparam csr_idx_type CSR_SPARE_HI = 2'd3;

   typedef struct {
      cmd_type  cmd;
      node_type node;
      mask_type mask;
      stat_type conn;
      stat_type cpu;
      stat_type mem;
      resp_type resp;
      logic     health;
   } command_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   cmd_type      req_cmd;
   node_type     req_node;
   mask_type     req_avail_mask;
   stat_type     req_conn_in;
   stat_type     req_cpu_in;
   stat_type     req_mem_in;
   resp_type     req_resp_in;
   logic         req_health_in;
   logic         rsp_valid;
   logic         rsp_ready;
   logic         rsp_ok;
   node_type     rsp_chosen;
   logic         rsp_present_out;
   logic         rsp_healthy_out;
   stat_type     rsp_conn_out;
   logic         csr_valid;
   logic         csr_ready;
   csr_idx_type  csr_index;
   csr_data_type csr_data;

   int mismatches;
   int outstanding;
   int hold_go;
   int burst_left;
   int items_sent;
   int selects_sent;
   int settings_used;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   node_selection_balancer u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_node        (req_node),
      .req_avail_mask  (req_avail_mask),
      .req_conn_in     (req_conn_in),
      .req_cpu_in      (req_cpu_in),
      .req_mem_in      (req_mem_in),
      .req_resp_in     (req_resp_in),
      .req_health_in   (req_health_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_chosen      (rsp_chosen),
      .rsp_present_out (rsp_present_out),
      .rsp_healthy_out (rsp_healthy_out),
      .rsp_conn_out    (rsp_conn_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   nsb_select_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_node        (req_node),
      .req_avail_mask  (req_avail_mask),
      .req_conn_in     (req_conn_in),
      .req_cpu_in      (req_cpu_in),
      .req_mem_in      (req_mem_in),
      .req_resp_in     (req_resp_in),
      .req_health_in   (req_health_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ok          (rsp_ok),
      .rsp_chosen      (rsp_chosen),
      .rsp_present_out (rsp_present_out),
      .rsp_healthy_out (rsp_healthy_out),
      .rsp_conn_out    (rsp_conn_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   function automatic command_type make_cmd(cmd_type cmd, node_type node, mask_type mask,
                                            stat_type conn, stat_type cpu, stat_type mem,
                                            resp_type resp, logic health);
      command_type c;
      c.cmd    = cmd;
      c.node   = node;
      c.mask   = mask;
      c.conn   = conn;
      c.cpu    = cpu;
      c.mem    = mem;
      c.resp   = resp;
      c.health = health;
      return c;
   endfunction

   // Small statistic values make ties in the minimum search likely
   function automatic stat_type random_stat();
      if ($urandom_range(0, 1) == 0)
         return stat_type'($urandom_range(0, 3));
      return stat_type'($urandom);
   endfunction

   function automatic command_type random_command();
      command_type c;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 20)      c.cmd = CMD_ADD;
      else if (pick < 28) c.cmd = CMD_REMOVE;
      else if (pick < 48) c.cmd = CMD_UPDATE;
      else if (pick < 60) c.cmd = CMD_HEALTH;
      else if (pick < 85) c.cmd = CMD_SELECT;
      else if (pick < 95) c.cmd = CMD_QUERY;
      else if (pick < 96) c.cmd = CMD_CLEAR;
      else                c.cmd = CMD_UNUSED;
      c.node = node_type'($urandom_range(0, MAX_SLOTS - 1));
      case ($urandom_range(0, 3))
         0:       c.mask = '1;
         1:       c.mask = mask_type'(1) << $urandom_range(0, MAX_SLOTS - 1);
         2:       c.mask = mask_type'($urandom) | mask_type'($urandom);
         default: c.mask = mask_type'($urandom);
      endcase
      c.conn = random_stat();
      c.cpu  = random_stat();
      c.mem  = random_stat();
      c.resp = ($urandom_range(0, 1) == 0) ? resp_type'($urandom_range(0, 3999))
                                            : resp_type'($urandom);
      c.health = ($urandom_range(0, 3) != 0);
      return c;
   endfunction

   task automatic send_command(command_type c);
      req_valid      <= 1'b1;
      req_cmd        <= c.cmd;
      req_node       <= c.node;
      req_avail_mask <= c.mask;
      req_conn_in    <= c.conn;
      req_cpu_in     <= c.cpu;
      req_mem_in     <= c.mem;
      req_resp_in    <= c.resp;
      req_health_in  <= c.health;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (c.cmd == CMD_SELECT)
         selects_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 20);
      end
   endtask

   // Hold the request side until every predicted item has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, csr_data_type value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic en, logic [1:0] sel_mode);
      csr_data_type junk;
      junk = csr_data_type'($urandom);
      write_reg(CSR_ENABLE, {junk[7:1], en});
      junk = csr_data_type'($urandom);
      write_reg(CSR_MODE, {junk[7:2], sel_mode});
      settings_used++;
   endtask

   // Receiver: random stall styles, plus a long hold-off on request
   initial begin
      int style;
      int span;
      int seen;
      rsp_ready = 1'b0;
      style = 0;
      span  = 0;
      seen  = 0;
      forever begin
         @(posedge clock);
         if (hold_go != seen) begin
            seen = hold_go;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (span == 0) begin
               style = $urandom_range(0, 3);
               span  = $urandom_range(10, 150);
            end
            span--;
            case (style)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 1) == 1);
               2:       rsp_ready <= ($urandom_range(0, 4) == 0);
               default: rsp_ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   initial begin
      #(RUN_LIMIT);
      $display("node_selection_balancer_tb: FAIL");
      $finish;
   end

   initial begin
      logic [1:0] sel_mode;
      logic       en;
      int         n;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_ADD;
      req_node       = '0;
      req_avail_mask = '0;
      req_conn_in    = '0;
      req_cpu_in     = '0;
      req_mem_in     = '0;
      req_resp_in    = '0;
      req_health_in  = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = CSR_ENABLE;
      csr_data       = '0;
      hold_go        = 0;
      items_sent     = 0;
      selects_sent   = 0;
      settings_used  = 0;
      burst_left     = $urandom_range(1, 30);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disabled: every command fails
      configure(1'b0, MODE_RR);
      send_command(make_cmd(CMD_ADD, 4'd0, '0, '0, '0, '0, '0, 1'b0));
      send_command(make_cmd(CMD_SELECT, 4'd0, '1, '0, '0, '0, '0, 1'b0));
      drain();
      write_reg(CSR_SPARE_LO, '1);
      write_reg(CSR_SPARE_HI, '1);

      configure(1'b1, MODE_RR);
      send_command(make_cmd(CMD_ADD, 4'd0, '0, '0, '0, '0, '0, 1'b0));
      send_command(make_cmd(CMD_ADD, 4'd0, '0, '0, '0, '0, '0, 1'b0));
      send_command(make_cmd(CMD_ADD, 4'd15, '0, '0, '0, '0, '0, 1'b0));
      send_command(make_cmd(CMD_REMOVE, 4'd3, '0, '0, '0, '0, '0, 1'b0));
      send_command(make_cmd(CMD_UPDATE, 4'd5, '1, '1, '1, '1, '1, 1'b1));
      send_command(make_cmd(CMD_UPDATE, 4'd0, '1, '1, '1, '1, '1, 1'b1));
      send_command(make_cmd(CMD_UPDATE, 4'd15, '0, '0, '0, '0, '0, 1'b0));
      // healthy slot that was never added
      send_command(make_cmd(CMD_HEALTH, 4'd7, '0, '0, '0, '0, '0, 1'b1));
      send_command(make_cmd(CMD_SELECT, 4'd0, '1, '0, '0, '0, '0, 1'b0));
      send_command(make_cmd(CMD_SELECT, 4'd9, '1, '0, '0, '0, '0, 1'b0));
      send_command(make_cmd(CMD_SELECT, 4'd0, '0, '0, '0, '0, '0, 1'b0));
      send_command(make_cmd(CMD_QUERY, 4'd0, '0, '0, '0, '0, '0, 1'b0));
      send_command(make_cmd(CMD_QUERY, 4'd7, '0, '0, '0, '0, '0, 1'b0));
      send_command(make_cmd(CMD_UNUSED, 4'd0, '1, '1, '1, '1, '1, 1'b1));
      send_command(make_cmd(CMD_HEALTH, 4'd15, '0, '0, '0, '0, '0, 1'b0));
      send_command(make_cmd(CMD_SELECT, 4'd0, 16'h8000, '0, '0, '0, '0, 1'b0));
      drain();

      configure(1'b1, MODE_LEAST);
      send_command(make_cmd(CMD_SELECT, 4'd0, '1, '0, '0, '0, '0, 1'b0));
      send_command(make_cmd(CMD_HEALTH, 4'd15, '0, '0, '0, '0, '0, 1'b1));
      send_command(make_cmd(CMD_SELECT, 4'd0, '1, '0, '0, '0, '0, 1'b0));
      drain();

      configure(1'b1, MODE_SCORE);
      send_command(make_cmd(CMD_SELECT, 4'd0, '1, '0, '0, '0, '0, 1'b0));
      send_command(make_cmd(CMD_REMOVE, 4'd0, '0, '0, '0, '0, '0, 1'b0));
      send_command(make_cmd(CMD_REMOVE, 4'd15, '0, '0, '0, '0, '0, 1'b0));
      // only an absent healthy candidate: falls back to the first one
      send_command(make_cmd(CMD_SELECT, 4'd0, 16'h0080, '0, '0, '0, '0, 1'b0));
      send_command(make_cmd(CMD_CLEAR, 4'd0, '0, '0, '0, '0, '0, 1'b0));
      send_command(make_cmd(CMD_SELECT, 4'd0, '1, '0, '0, '0, '0, 1'b0));

      for (int p = 0; p < PHASES; p++) begin
         drain();
         sel_mode = 2'(p % 4);
         en = (p != 6);
         n = en ? PHASE_ITEMS : IDLE_ITEMS;
         configure(en, sel_mode);
         for (int i = 0; i < n; i++) begin
            // stall the receiver long enough to back up the request side
            if (p == 4 && i == 10)
               hold_go <= hold_go + 1;
            send_command(random_command());
         end
      end
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run covered %0d command items, %0d of them selects, under %0d register settings",
               items_sent, selects_sent, settings_used);
      $display("with bursty requests, receiver stalls and one long response hold-off");
      if (mismatches == 0 && outstanding == 0) begin
         $display("node_selection_balancer_tb: PASS");
      end else begin
         if (outstanding != 0)
            $error("%0d response items never arrived", outstanding);
         $display("node_selection_balancer_tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/nsb_pkg.sv
design/node_selection_balancer.sv
sim/nsb_select_checker.sv
sim/node_selection_balancer_tb.sv
